[rtl/packed_genotype_dot_product_assert.svh]
// assertion macros shared by the rtl files
`ifndef PACKED_GENOTYPE_DOT_PRODUCT_ASSERT_SVH
`define PACKED_GENOTYPE_DOT_PRODUCT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PGDP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pgdp check failed");

// next-cycle implication, checked out of reset
`define PGDP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pgdp check failed");

`endif

[rtl/pgdp_pkg.sv]
package pgdp_pkg;

   localparam int WORD_BITS   = 64;
   localparam int SUM_W       = 24;
   localparam int LANE_CODES  = 8;
   localparam int LANE_BITS   = 2 * LANE_CODES;
   localparam int CODE_SCORE_W = 3;
   // 8 codes * 6 max each = 48
   localparam int LANE_SUM_W  = 6;
   // 32 codes * 6 max each = 192
   localparam int WORD_SUM_W  = 8;

   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   typedef logic [CODE_SCORE_W-1:0] score_tbl_type [4];

   localparam score_tbl_type AND_VALUE = '{3'd0, 3'd1, 3'd4, 3'd0};
   localparam score_tbl_type OR_VALUE  = '{3'd0, 3'd0, 3'd0, 3'd2};

   typedef struct packed {
      logic go;
      logic last;
   } merge_ctrl_type;

   // score of one code position: and-table plus or-table
   function automatic logic [CODE_SCORE_W-1:0] code_score(input logic [1:0] a,
                                                          input logic [1:0] b);
      logic [1:0] x;
      logic [1:0] y;
      x = a & b;
      y = a | b;
      return AND_VALUE[x] + OR_VALUE[y];
   endfunction

endpackage

[rtl/pgdp_req_if.sv]
interface pgdp_req_if import pgdp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [WORD_BITS-1:0] word_a;
   logic [WORD_BITS-1:0] word_b;
   logic                 last_word;

   modport source (output valid, output word_a, output word_b, output last_word,
                   input ready);
   modport sink (input valid, input word_a, input word_b, input last_word,
                 output ready);
endinterface

[rtl/pgdp_rsp_if.sv]
interface pgdp_rsp_if import pgdp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [SUM_W-1:0] dot_sum;

   modport source (output valid, output dot_sum, input ready);
   modport sink (input valid, input dot_sum, output ready);
endinterface

[rtl/pgdp_lane.sv]
module pgdp_lane import pgdp_pkg::*; #(
   parameter int ACTIVE_CODES = 8
) (
   input  logic                  clock,
   input  logic                  load,
   input  logic [LANE_BITS-1:0]  codes_a,
   input  logic [LANE_BITS-1:0]  codes_b,
   output logic [LANE_SUM_W-1:0] lane_sum
);

   logic [LANE_SUM_W-1:0] sum_ff;
   logic [LANE_SUM_W-1:0] sum_in;

   always_comb begin
      sum_in = '0;
      for (int p = 0; p < LANE_CODES; p++) begin
         if (p < ACTIVE_CODES) begin
            sum_in = sum_in + LANE_SUM_W'(code_score(codes_a[2*p +: 2],
                                                     codes_b[2*p +: 2]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sum_ff <= sum_in;
      end
   end

   assign lane_sum = sum_ff;

endmodule

[rtl/pgdp_merge.sv]
`include "packed_genotype_dot_product_assert.svh"

module pgdp_merge import pgdp_pkg::*; #(
   parameter int NUM_LANES = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  merge_ctrl_type        ctrl,
   input  logic [LANE_SUM_W-1:0] lane_sum [NUM_LANES],
   input  logic                  rsp_taken,
   output logic                  rsp_valid,
   output logic [SUM_W-1:0]      dot_sum
);

   logic [WORD_SUM_W-1:0] word_sum;
   logic [SUM_W:0]        total_wide;
   logic [SUM_W-1:0]      total;
   logic [SUM_W-1:0]      acc_ff;
   logic [SUM_W-1:0]      acc_in;
   logic [SUM_W-1:0]      result_ff;
   logic [SUM_W-1:0]      result_in;
   logic                  valid_ff;
   logic                  valid_in;

   // combine the lane sums
   always_comb begin
      word_sum = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
         word_sum = word_sum + WORD_SUM_W'(lane_sum[i]);
      end
   end

   assign total_wide = {1'b0, acc_ff} + (SUM_W + 1)'(word_sum);
   assign total      = total_wide[SUM_W] ? SUM_MAX : total_wide[SUM_W-1:0];

   always_comb begin
      acc_in    = acc_ff;
      result_in = result_ff;
      valid_in  = valid_ff & ~rsp_taken;
      if (ctrl.go) begin
         if (ctrl.last) begin
            acc_in    = '0;
            result_in = total;
            valid_in  = 1'b1;
         end else begin
            acc_in = total;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_valid = valid_ff;
   assign dot_sum   = result_ff;

   `PGDP_ASSERT_NEXT(a_clear_on_last, clock, reset, ctrl.go && ctrl.last, acc_ff == '0)
   `PGDP_ASSERT_NEXT(a_hold_result, clock, reset, valid_ff && !rsp_taken,
                     valid_ff && $stable(result_ff))
   `PGDP_ASSERT_NOW(a_no_overwrite, clock, reset, ctrl.go && ctrl.last,
                    !valid_ff || rsp_taken)

endmodule

[rtl/packed_genotype_dot_product.sv]
// packed genotype dot product
// req channel: one word per handshake, word_a and word_b each pack
//    CODES_PER_WORD two-bit genotype codes, code p in bits 2p+1..2p;
//    last_word marks the final word of an individual pair
// rsp channel: one word per pair, dot_sum = saturating sum of the genotype
//    products over all words of the pair
// structure: lanes of eight codes score a word in parallel into lane
//    registers, a merge stage adds the lanes into the running sum
// result: the sum of a last word passes the lane register, then the output
//    register, before it can be taken from rsp
// throughput: one word per cycle while no last word is held back (see stall),
//    as the lane score and the accumulate in the merge stage never hold a word
// stall: while a result waits in the output register, non-last words keep
//    flowing; a last word waits in the lane stage until the result is taken,
//    and req.ready drops only then
// reset: synchronous, clears the running sum and all valid flags
`include "packed_genotype_dot_product_assert.svh"

module packed_genotype_dot_product import pgdp_pkg::*; #(
   parameter int CODES_PER_WORD = 32
) (
   input logic         clock,
   input logic         reset,
   pgdp_req_if.sink    req_chan,
   pgdp_rsp_if.source  rsp_chan
);

   localparam int NUM_LANES = (CODES_PER_WORD + LANE_CODES - 1) / LANE_CODES;

   // lane stage control
   logic s1_valid_ff;
   logic s1_valid_in;
   logic s1_last_ff;
   logic s1_last_in;
   logic req_take;
   logic rsp_taken;
   logic out_free;
   merge_ctrl_type merge_ctrl;

   logic [LANE_SUM_W-1:0] lane_sum [NUM_LANES];
   logic rsp_valid;

   assign rsp_taken = rsp_valid & rsp_chan.ready;
   // output register can take a new result this cycle
   assign out_free  = ~rsp_valid | rsp_chan.ready;

   // merge fires on a valid lane word unless it is a last word that finds the output slot full
   assign merge_ctrl.go   = s1_valid_ff & (~s1_last_ff | out_free);
   assign merge_ctrl.last = s1_last_ff;

   assign req_chan.ready = ~s1_valid_ff | merge_ctrl.go;
   assign req_take       = req_chan.valid & req_chan.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_last_in  = s1_last_ff;
      if (req_chan.ready) begin
         s1_valid_in = req_chan.valid;
         s1_last_in  = req_chan.last_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff <= s1_last_in;
   end

   // scoring lanes, the last one may carry fewer codes
   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      localparam int LANE_N = (CODES_PER_WORD - i * LANE_CODES >= LANE_CODES) ?
                              LANE_CODES : CODES_PER_WORD - i * LANE_CODES;
      pgdp_lane #(
         .ACTIVE_CODES(LANE_N)
      ) u_lane (
         .clock    (clock),
         .load     (req_take),
         .codes_a  (req_chan.word_a[i*LANE_BITS +: LANE_BITS]),
         .codes_b  (req_chan.word_b[i*LANE_BITS +: LANE_BITS]),
         .lane_sum (lane_sum[i])
      );
   end

   // lane merge, running sum and output register
   pgdp_merge #(
      .NUM_LANES(NUM_LANES)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (merge_ctrl),
      .lane_sum  (lane_sum),
      .rsp_taken (rsp_taken),
      .rsp_valid (rsp_valid),
      .dot_sum   (rsp_chan.dot_sum)
   );

   assign rsp_chan.valid = rsp_valid;

   `PGDP_ASSERT_NEXT(a_take_fills_lane, clock, reset, req_take, s1_valid_ff)
   `PGDP_ASSERT_NEXT(a_lane_holds, clock, reset, s1_valid_ff && !merge_ctrl.go,
                     s1_valid_ff && $stable(s1_last_ff))
   `PGDP_ASSERT_NOW(a_ready_when_empty, clock, reset, !s1_valid_ff, req_chan.ready)

endmodule

[tb/tb_top.sv]
module tb_top;
   import pgdp_pkg::*;

   // codes per word, kept equal to the block's default
   localparam int CODES = 32;
   // run ends with a failure if it gets this far
   localparam int unsigned CYCLE_LIMIT = 200_000;
   // one long pair of maximum-score words sent back to back
   localparam int unsigned STEADY_WORDS = 40;
   // about this many random words
   localparam int unsigned RANDOM_WORDS = 640;
   // receiver backpressure: one long hold once this many sums have come
   localparam int unsigned HOLD_AFTER = 30;
   localparam int unsigned HOLD_CYCLES = 400;

   // per-code gain of the and-code and the or-code
   localparam int unsigned AND_GAIN [4] = '{0, 1, 4, 0};
   localparam int unsigned OR_GAIN [4] = '{0, 0, 0, 2};

   // handy packed patterns: every code 3, 2, 1
   localparam logic [WORD_BITS-1:0] ALL3 = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [WORD_BITS-1:0] ALL2 = 64'hAAAA_AAAA_AAAA_AAAA;
   localparam logic [WORD_BITS-1:0] ALL1 = 64'h5555_5555_5555_5555;

   // one word pair waiting to be sent
   typedef struct {
      logic [WORD_BITS-1:0] word_a;
      logic [WORD_BITS-1:0] word_b;
      logic                 last_word;
      bit                   drain;   // hold back until every sum is back
      bit                   steady;  // no gap after this word
   } geno_word_type;

   logic clock;
   logic reset;

   pgdp_req_if req_chan ();
   pgdp_rsp_if rsp_chan ();

   packed_genotype_dot_product #(
      .CODES_PER_WORD(CODES)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   geno_word_type        word_backlog [$];   // words still to send
   logic [SUM_W-1:0]     dot_sums_due [$];   // predicted sums, oldest first
   logic [SUM_W:0]       pair_sum;           // predicted running sum of the open pair
   int unsigned          sums_seen = 0;
   int unsigned          error_count = 0;
   int unsigned          cycle_count = 0;
   int unsigned          req_gap;
   int unsigned          rsp_gap;
   int unsigned          rsp_calm;
   int unsigned          hold_left;
   bit                   hold_done;

   // clock, 10 time units
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------

   // genotype product of one word pair, summed over all code positions;
   // the and-code scores 1 and 2, the or-code scores mixed 1/2 and any 3
   function automatic int unsigned genotype_word_score(logic [WORD_BITS-1:0] a,
                                                       logic [WORD_BITS-1:0] b);
      logic [WORD_BITS-1:0] both;
      logic [WORD_BITS-1:0] either;
      int unsigned          s;
      both = a & b;
      either = a | b;
      s = 0;
      for (int p = 0; p < CODES; p++) begin
         s += AND_GAIN[both[2*p +: 2]] + OR_GAIN[either[2*p +: 2]];
      end
      return s;
   endfunction

   task automatic flag_mismatch(string what, logic [SUM_W-1:0] got, logic [SUM_W-1:0] want);
      $display("[%0d] mismatch: %s got %0d want %0d", cycle_count, what, got, want);
      error_count++;
   endtask

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   // word of real genotypes: codes 0, 1, 2 only
   function automatic logic [WORD_BITS-1:0] genotype_word();
      logic [WORD_BITS-1:0] w;
      w = '0;
      for (int p = 0; p < CODES; p++) begin
         w[2*p +: 2] = 2'($urandom_range(0, 2));
      end
      return w;
   endfunction

   // mostly short stalls, now and then a long one
   function automatic int unsigned stall_len();
      return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
   endfunction

   function automatic int unsigned send_gap();
      return ($urandom_range(0, 99) < 55) ? 0 : stall_len();
   endfunction

   task automatic queue_word(logic [WORD_BITS-1:0] a, logic [WORD_BITS-1:0] b,
                             logic last, bit drain = 1'b0, bit steady = 1'b0);
      geno_word_type w;
      w.word_a = a;
      w.word_b = b;
      w.last_word = last;
      w.drain = drain;
      w.steady = steady;
      word_backlog.push_back(w);
   endtask

   // ---------------------------------------------------------------------
   // driver: presents one word at a time from the backlog
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : word_driver
      geno_word_type nxt;
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_gap <= 0;
      end else if (req_chan.valid && !req_chan.ready) begin
         // word on offer and not taken yet, keep it steady
      end else if (req_gap != 0) begin
         req_chan.valid <= 1'b0;
         req_gap <= req_gap - 1;
      end else if (word_backlog.size() != 0 &&
                   !(word_backlog[0].drain && (req_chan.valid || dot_sums_due.size() != 0))) begin
         // a drain word waits until no word is on offer, so the last taken word is predicted,
         // then until every predicted sum has come back
         nxt = word_backlog.pop_front();
         req_chan.valid <= 1'b1;
         req_chan.word_a <= nxt.word_a;
         req_chan.word_b <= nxt.word_b;
         req_chan.last_word <= nxt.last_word;
         req_gap <= nxt.steady ? 0 : send_gap();
      end else begin
         req_chan.valid <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // receiver: random stalls, calm stretches, one long hold
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_gap <= 0;
         rsp_calm <= 0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && sums_seen >= HOLD_AFTER) begin
         // long hold while the sender keeps going, the block has to back up
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_chan.ready <= 1'b0;
      end else if (rsp_gap != 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_gap <= rsp_gap - 1;
         if (rsp_gap == 1 && $urandom_range(0, 4) == 0) begin
            rsp_calm <= $urandom_range(50, 200);
         end
      end else if (rsp_calm != 0) begin
         rsp_chan.ready <= 1'b1;
         rsp_calm <= rsp_calm - 1;
      end else if ($urandom_range(0, 99) < 20) begin
         rsp_chan.ready <= 1'b0;
         rsp_gap <= stall_len() - 1;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // monitor: predicts on every taken word, checks every taken sum
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : sum_monitor
      logic [SUM_W:0]   total;
      logic [SUM_W-1:0] want;
      if (reset) begin
         pair_sum = '0;
      end else begin
         // prediction first, so a sum that comes at once still finds its entry
         if (req_chan.valid && req_chan.ready) begin
            total = pair_sum + (SUM_W+1)'(genotype_word_score(req_chan.word_a, req_chan.word_b));
            // saturate at the 24-bit ceiling
            if (total > {1'b0, SUM_MAX}) begin
               total = {1'b0, SUM_MAX};
            end
            if (req_chan.last_word) begin
               dot_sums_due.push_back(total[SUM_W-1:0]);
               pair_sum = '0;
            end else begin
               pair_sum = total;
            end
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            sums_seen++;
            if (dot_sums_due.size() == 0) begin
               flag_mismatch("dot_sum with no pair pending", rsp_chan.dot_sum, '0);
            end else begin
               want = dot_sums_due.pop_front();
               if (rsp_chan.dot_sum !== want) begin
                  flag_mismatch("dot_sum", rsp_chan.dot_sum, want);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int unsigned          words;
      int unsigned          len;
      bit                   raw;
      bit                   steady;
      bit                   drain;
      logic [WORD_BITS-1:0] a;
      logic [WORD_BITS-1:0] b;

      reset = 1'b1;

      // directed: one-word pairs over the code combinations
      queue_word('0, '0, 1'b1);                // nothing
      queue_word(ALL3, ALL3, 1'b1);            // 3 with 3 gives 2
      queue_word(ALL2, ALL2, 1'b1);            // 2 with 2 gives 4
      queue_word(ALL1, ALL1, 1'b1);            // 1 with 1 gives 1
      queue_word(ALL2, ALL1, 1'b1);            // 2 with 1 gives 2
      queue_word(ALL3, ALL1, 1'b1);            // 3 with 1 gives 3
      queue_word(ALL3, ALL2, 1'b1);            // 3 with 2 gives 6, word maximum
      queue_word(ALL3, '0, 1'b1);              // 3 with 0 gives 2
      queue_word(64'hC000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b1);  // top code only
      queue_word(64'h3, 64'h2, 1'b1);          // bottom code only
      // a pair of several words, non-last words return nothing
      queue_word(ALL2, ALL2, 1'b0);
      queue_word(ALL1, ALL2, 1'b0);
      queue_word('0, ALL3, 1'b0);
      queue_word(genotype_word(), genotype_word(), 1'b0);
      queue_word(ALL3, ALL2, 1'b1);

      // a long pair of maximum-score words with no gaps, then a short one
      for (int unsigned k = 0; k < STEADY_WORDS; k++) begin
         queue_word(ALL3, ALL2, 1'b0, 1'b0, 1'b1);
      end
      queue_word(ALL3, ALL2, 1'b1, 1'b0, 1'b1);
      queue_word(ALL1, ALL1, 1'b1);

      // random pairs: mostly short, some long; mostly real genotypes
      words = 0;
      while (words < RANDOM_WORDS) begin
         len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 40);
         raw = ($urandom_range(0, 3) == 0);
         steady = ($urandom_range(0, 3) == 0);
         // first random word waits for the pipe to empty, a few others too
         drain = (words == 0) || ($urandom_range(0, 49) == 0);
         for (int unsigned k = 0; k < len; k++) begin
            a = raw ? {$urandom, $urandom} : genotype_word();
            b = raw ? {$urandom, $urandom} : genotype_word();
            queue_word(a, b, k == len - 1, drain && k == 0, steady);
         end
         words += len;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // let every word go out and every sum come back
      while (word_backlog.size() != 0 || req_chan.valid || dot_sums_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);

      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

[packed_genotype_dot_product.f]
+incdir+rtl
rtl/pgdp_pkg.sv
rtl/pgdp_req_if.sv
rtl/pgdp_rsp_if.sv
rtl/pgdp_lane.sv
rtl/pgdp_merge.sv
rtl/packed_genotype_dot_product.sv
tb/tb_top.sv
